// File: rtl/gwf_pkg.sv
// Package for the Gaussian window filter.
// Holds sizes, register indexes, border modes and the shared struct types.
// No dependencies.
`default_nettype none

package gwf_pkg;

  localparam int MAX_RADIUS  = 3;
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int TAP_BITS    = 16;
  localparam int TAP_SLOT    = 16;
  localparam int NUM_TAPS    = 2 * MAX_RADIUS + 1;
  localparam int TAP_IDX_W   = $clog2(NUM_TAPS);
  localparam int RING_ROWS   = 2 * MAX_RADIUS + 2;
  localparam int RING_W      = $clog2(RING_ROWS);
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int ADDR_W      = RING_W + COL_W;
  localparam int STORE_DEPTH = RING_ROWS * MAX_WIDTH;
  localparam int POS_W       = ROW_W + 3;
  localparam int DIM_W       = 11;
  localparam int CFG_W       = 64;
  localparam int HI_W        = 48;
  localparam int IDX_W       = 3;
  localparam int PIX_W       = 8;
  localparam int WT_W        = 2 * TAP_BITS;
  localparam int PROD_W      = WT_W + PIX_W;
  localparam int ACC_W       = PROD_W + 6;
  localparam int WSUM_W      = WT_W + 6;
  localparam int QUOT_W      = PIX_W + 1;
  localparam int DIV_CNT_W   = 4;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  // rows at least this wide let the front run ahead of the back end
  localparam int SAFE_WIDTH  = 16;

  typedef enum logic [IDX_W-1:0] {
    REG_RADIUS = 3'd0,
    REG_BORDER = 3'd1,
    REG_WIDTH  = 3'd2,
    REG_HEIGHT = 3'd3,
    REG_VLO    = 3'd4,
    REG_VHI    = 3'd5,
    REG_HLO    = 3'd6,
    REG_HHI    = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    BM_ZERO   = 2'd0,
    BM_MIRROR = 2'd1,
    BM_RENORM = 2'd2
  } bmode_e;

  typedef struct packed {
    logic [1:0]                         rad;
    bmode_e                             mode;
    logic [COL_W-1:0]                   wm1;
    logic [ROW_W-1:0]                   hm1;
    logic [NUM_TAPS-1:0][TAP_BITS-1:0]  vtap;
    logic [NUM_TAPS-1:0][TAP_BITS-1:0]  htap;
  } cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             is_last;
  } job_t;

endpackage

`default_nettype wire

// File: rtl/gwf_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module gwf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/gwf_queue.sv
// Short job queue between the front end and the filter back end.
// Depends on gwf_pkg.
`default_nettype none

module gwf_queue import gwf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  input  logic pop_i,
  output job_t data_o,
  output logic full_o,
  output logic empty_o
);

  job_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wp_q, rp_q;
  logic [QPTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (QPTR_W+1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: rtl/gwf_front.sv
// Front end: configuration registers, request intake, position tracking,
// line store writes and job generation. Depends on gwf_pkg.
`default_nettype none

module gwf_front import gwf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [PIX_W-1:0]  pixel_i,
  input  logic              drain_i,
  input  logic              back_idle_i,
  input  logic              q_full_i,
  input  logic              q_empty_i,
  output logic              push_o,
  output job_t              job_o,
  output logic              wr_en_o,
  output logic [ADDR_W-1:0] wr_addr_o,
  output logic [PIX_W-1:0]  wr_data_o,
  output cfg_t              cfg_o
);

  logic [1:0]        radius_q, border_q;
  logic [DIM_W-1:0]  width_q, height_q;
  logic [CFG_W-1:0]  vlo_q, hlo_q;
  logic [HI_W-1:0]   vhi_q, hhi_q;

  logic [ROW_W:0]    in_row_q;
  logic [COL_W-1:0]  in_col_q, out_col_q;
  logic [ROW_W-1:0]  out_row_q;
  logic [2*DIM_W-1:0] pos_q;

  logic [DIM_W-1:0]  w_eff, h_eff;
  logic [COL_W-1:0]  wm1;
  logic [ROW_W-1:0]  hm1;
  logic [CFG_W+HI_W-1:0] vall, hall;
  logic              accept, pix_phase, ignore, advance, emit, before_lat;
  logic              is_last, wide, at_start, restart;
  logic [2*DIM_W-1:0] lat;

  always_comb begin
    if (width_q == '0)                        w_eff = DIM_W'(1);
    else if (width_q > DIM_W'(MAX_WIDTH))     w_eff = DIM_W'(MAX_WIDTH);
    else                                      w_eff = width_q;
    if (height_q == '0)                       h_eff = DIM_W'(1);
    else if (height_q > DIM_W'(MAX_HEIGHT))   h_eff = DIM_W'(MAX_HEIGHT);
    else                                      h_eff = height_q;
  end

  assign wm1  = COL_W'(w_eff - DIM_W'(1));
  assign hm1  = ROW_W'(h_eff - DIM_W'(1));
  assign vall = {vhi_q, vlo_q};
  assign hall = {hhi_q, hlo_q};

  always_comb begin
    cfg_o.rad = radius_q;
    cfg_o.wm1 = wm1;
    cfg_o.hm1 = hm1;
    if (border_q == BM_MIRROR)      cfg_o.mode = BM_MIRROR;
    else if (border_q == BM_RENORM) cfg_o.mode = BM_RENORM;
    else                            cfg_o.mode = BM_ZERO;
    for (int k = 0; k < NUM_TAPS; k++) begin
      cfg_o.vtap[k] = vall[TAP_SLOT*k +: TAP_BITS];
      cfg_o.htap[k] = hall[TAP_SLOT*k +: TAP_BITS];
    end
  end

  // linear position of the first output: radius rows plus radius pixels
  assign lat        = (2*DIM_W)'(radius_q) * (2*DIM_W)'(w_eff) + (2*DIM_W)'(radius_q);
  assign pix_phase  = (in_row_q <= {1'b0, hm1});
  assign before_lat = (pos_q < lat);
  assign is_last    = (out_row_q == hm1) && (out_col_q == wm1);
  assign wide       = (wm1 >= COL_W'(SAFE_WIDTH - 1));
  assign at_start   = (in_row_q == '0) && (in_col_q == '0);

  // narrow rows or a new frame wait for the back end to finish reading
  assign in_ready_o = !q_full_i && ((wide && !at_start) || (q_empty_i && back_idle_i));

  assign accept  = in_valid_i && in_ready_o;
  assign ignore  = pix_phase && drain_i;
  assign advance = accept && !ignore;
  assign emit    = advance && !before_lat;
  assign restart = cfg_we_i && (cfg_idx_i < REG_VLO);

  assign wr_en_o   = accept && pix_phase && !drain_i;
  assign wr_addr_o = {in_row_q[RING_W-1:0], in_col_q};
  assign wr_data_o = pixel_i;

  assign push_o        = emit;
  assign job_o.row     = out_row_q;
  assign job_o.col     = out_col_q;
  assign job_o.is_last = is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 2'd3;
      border_q <= BM_RENORM;
      width_q  <= DIM_W'(MAX_WIDTH);
      height_q <= DIM_W'(MAX_HEIGHT);
      vlo_q    <= '0;
      vhi_q    <= '0;
      hlo_q    <= '0;
      hhi_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_RADIUS: radius_q <= cfg_data_i[1:0];
        REG_BORDER: border_q <= cfg_data_i[1:0];
        REG_WIDTH:  width_q  <= cfg_data_i[DIM_W-1:0];
        REG_HEIGHT: height_q <= cfg_data_i[DIM_W-1:0];
        REG_VLO:    vlo_q    <= cfg_data_i;
        REG_VHI:    vhi_q    <= cfg_data_i[HI_W-1:0];
        REG_HLO:    hlo_q    <= cfg_data_i;
        REG_HHI:    hhi_q    <= cfg_data_i[HI_W-1:0];
        default:    radius_q <= radius_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
      pos_q     <= '0;
    end else if (restart || (emit && is_last)) begin
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
      pos_q     <= '0;
    end else begin
      if (advance) begin
        pos_q <= pos_q + 1'b1;
        if (in_col_q == wm1) begin
          in_col_q <= '0;
          in_row_q <= in_row_q + 1'b1;
        end else begin
          in_col_q <= in_col_q + 1'b1;
        end
      end
      if (emit) begin
        if (out_col_q == wm1) begin
          out_col_q <= '0;
          out_row_q <= out_row_q + 1'b1;
        end else begin
          out_col_q <= out_col_q + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/gwf_back.sv
// Back end: walks one job's window, multiply-accumulates via a short pipeline,
// renormalizes by restoring division in renormalize mode. Depends on gwf_pkg.
`default_nettype none

module gwf_back import gwf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  job_t              job_i,
  input  logic              q_empty_i,
  output logic              pop_o,
  output logic              idle_o,
  output logic              rd_en_o,
  output logic [ADDR_W-1:0] rd_addr_o,
  input  logic [PIX_W-1:0]  rd_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [PIX_W-1:0]  filtered_o,
  output logic              last_of_frame_o
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DIV, S_OUT} state_e;

  state_e                state_q;
  job_t                  job_q;
  logic [TAP_IDX_W-1:0]  ai_q, bi_q;
  logic                  issuing_q, v1_q, v2_q, v3_q, u1_q, u2_q, u3_q;
  logic [TAP_BITS-1:0]   vt1_q, ht1_q;
  logic [WT_W-1:0]       wt2_q, wt3_q;
  logic [PIX_W-1:0]      pix2_q;
  logic [PROD_W-1:0]     prod3_q;
  logic [ACC_W-1:0]      acc_q, rem_q, dvs_q, rem_nx;
  logic [WSUM_W-1:0]     wsum_q;
  logic [QUOT_W-1:0]     quot_q, quot_nx;
  logic [DIV_CNT_W-1:0]  cnt_q;
  logic [PIX_W-1:0]      res_q;
  logic                  last_q;

  logic [TAP_IDX_W-1:0]  span;
  logic signed [POS_W-1:0] rr, cc, rs, cs, last_r, last_c;
  logic                  use_e, issue, drained, start_div;
  logic [PIX_W-1:0]      plain_res;

  function automatic logic signed [POS_W-1:0] mirror(input logic signed [POS_W-1:0] i,
                                                     input logic signed [POS_W-1:0] lim);
    logic signed [POS_W-1:0] m;
    m = i;
    if (i < 0)        m = -i;
    else if (i > lim) m = (lim <<< 1) - i;
    if (m < 0)   m = '0;
    if (m > lim) m = lim;
    return m;
  endfunction

  assign span   = {cfg_i.rad, 1'b0};
  assign last_r = $signed(POS_W'(cfg_i.hm1));
  assign last_c = $signed(POS_W'(cfg_i.wm1));
  assign rr = $signed(POS_W'(job_q.row)) + $signed(POS_W'(ai_q)) - $signed(POS_W'(cfg_i.rad));
  assign cc = $signed(POS_W'(job_q.col)) + $signed(POS_W'(bi_q)) - $signed(POS_W'(cfg_i.rad));

  always_comb begin
    if (cfg_i.mode == BM_MIRROR) begin
      rs    = mirror(rr, last_r);
      cs    = mirror(cc, last_c);
      use_e = 1'b1;
    end else begin
      rs    = rr;
      cs    = cc;
      use_e = (rr >= 0) && (rr <= last_r) && (cc >= 0) && (cc <= last_c);
    end
  end

  assign issue     = (state_q == S_RUN) && issuing_q;
  assign rd_en_o   = issue;
  assign rd_addr_o = {rs[RING_W-1:0], cs[COL_W-1:0]};
  assign pop_o     = (state_q == S_IDLE) && !q_empty_i;
  assign idle_o    = (state_q == S_IDLE);
  assign drained   = !issuing_q && !v1_q && !v2_q && !v3_q;
  assign start_div = (state_q == S_RUN) && drained && (cfg_i.mode == BM_RENORM)
                     && (wsum_q != '0);

  assign plain_res = (|acc_q[ACC_W-1:WT_W+PIX_W]) ? '1 : acc_q[WT_W +: PIX_W];

  always_comb begin
    if (rem_q >= dvs_q) begin
      rem_nx  = rem_q - dvs_q;
      quot_nx = {quot_q[QUOT_W-2:0], 1'b1};
    end else begin
      rem_nx  = rem_q;
      quot_nx = {quot_q[QUOT_W-2:0], 1'b0};
    end
  end

  assign out_valid_o     = (state_q == S_OUT);
  assign filtered_o      = res_q;
  assign last_of_frame_o = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ai_q      <= '0;
      bi_q      <= '0;
      issuing_q <= 1'b0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      cnt_q     <= '0;
      res_q     <= '0;
      last_q    <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      unique case (state_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            ai_q      <= '0;
            bi_q      <= '0;
            issuing_q <= 1'b1;
            state_q   <= S_RUN;
          end
        end
        S_RUN: begin
          if (issuing_q) begin
            if (bi_q == span) begin
              bi_q <= '0;
              if (ai_q == span) issuing_q <= 1'b0;
              else              ai_q <= ai_q + 1'b1;
            end else begin
              bi_q <= bi_q + 1'b1;
            end
          end else if (drained) begin
            last_q <= job_q.is_last;
            if (cfg_i.mode == BM_RENORM) begin
              if (wsum_q == '0) begin
                res_q   <= '0;
                state_q <= S_OUT;
              end else begin
                cnt_q   <= '0;
                state_q <= S_DIV;
              end
            end else begin
              res_q   <= plain_res;
              state_q <= S_OUT;
            end
          end
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DIV_CNT_W'(QUOT_W - 1)) begin
            res_q   <= quot_nx[QUOT_W-1] ? '1 : quot_nx[PIX_W-1:0];
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    u1_q    <= use_e;
    u2_q    <= u1_q;
    u3_q    <= u2_q;
    vt1_q   <= cfg_i.vtap[ai_q];
    ht1_q   <= cfg_i.htap[bi_q];
    wt2_q   <= vt1_q * ht1_q;
    pix2_q  <= rd_data_i;
    prod3_q <= wt2_q * pix2_q;
    wt3_q   <= wt2_q;
    if (pop_o) begin
      job_q  <= job_i;
      acc_q  <= '0;
      wsum_q <= '0;
    end else if (v3_q && u3_q) begin
      acc_q  <= acc_q + ACC_W'(prod3_q);
      wsum_q <= wsum_q + WSUM_W'(wt3_q);
    end
    if (start_div) begin
      rem_q  <= acc_q;
      dvs_q  <= {wsum_q, PIX_W'(0)};
      quot_q <= '0;
    end else if (state_q == S_DIV) begin
      rem_q  <= rem_nx;
      dvs_q  <= dvs_q >> 1;
      quot_q <= quot_nx;
    end
  end

endmodule

`default_nettype wire

// File: rtl/gaussian_window_filter.sv
// A result leaves after its job's window is walked and the multiply-accumulate
// pipeline drains, plus a division in renormalize mode; the back end walks one
// window tap per cycle and takes no new job until the last result is accepted.
// Rows narrower than 16 pixels and frame starts wait for the back end.
// Reset: registers to defaults, positions to zero; line store not cleared.
// Depends on gwf_pkg, gwf_front, gwf_queue, gwf_ram, gwf_back.
`default_nettype none

module gaussian_window_filter import gwf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [PIX_W-1:0] pixel_i,
  input  logic             drain_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [PIX_W-1:0] filtered_o,
  output logic             last_of_frame_o
);

  cfg_t              cfg;
  job_t              job_in, job_out;
  logic              push, pop, q_full, q_empty, back_idle;
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [PIX_W-1:0]  wr_data, rd_data;

  gwf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pixel_i     (pixel_i),
    .drain_i     (drain_i),
    .back_idle_i (back_idle),
    .q_full_i    (q_full),
    .q_empty_i   (q_empty),
    .push_o      (push),
    .job_o       (job_in),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .cfg_o       (cfg)
  );

  gwf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .pop_i   (pop),
    .data_o  (job_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  gwf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  gwf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .job_i           (job_out),
    .q_empty_i       (q_empty),
    .pop_o           (pop),
    .idle_o          (back_idle),
    .rd_en_o         (rd_en),
    .rd_addr_o       (rd_addr),
    .rd_data_i       (rd_data),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .filtered_o      (filtered_o),
    .last_of_frame_o (last_of_frame_o)
  );

endmodule

`default_nettype wire

// File: rtl/gwf_checker.sv
// Port-level checks for the Gaussian window filter, bound to the top level.
// Depends on gwf_pkg and gaussian_window_filter.
`default_nettype none

module gwf_checker import gwf_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [PIX_W-1:0] filtered_o,
  input logic             last_of_frame_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(filtered_o) && $stable(last_of_frame_o))
    else $error("result payload changed while stalled");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  a_gap_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> !out_valid_o)
    else $error("back end produced results in consecutive cycles");

endmodule

bind gaussian_window_filter gwf_checker u_gwf_checker (.*);

`default_nettype wire
